/* src/wed_pkg.sv */
// Shared types and constants for the watering event detector.
package wed_pkg;

  // Field widths
  localparam int unsigned POT_W    = 3;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned WALL_W   = 32;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_DW    = 96;
  localparam int unsigned OUT_DW   = 64;

  // Output queue depth: one word in flight plus slack for a stalled consumer
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PW    = 2;
  localparam int unsigned OQ_CW    = 3;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_MIN_VALID  = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_STABLE     = 2'd2,
    CFG_CONFIRM_MS = 2'd3
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [THR_W-1:0] MIN_VALID_RST = 23'd100;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 23'd500;
  localparam logic [THR_W-1:0] STABLE_RST    = 23'd50;
  localparam logic [MS_W-1:0]  CONFIRM_RST   = 32'd10000;

  typedef struct packed {
    logic [THR_W-1:0] min_valid;
    logic [THR_W-1:0] threshold;
    logic [THR_W-1:0] stable;
    logic [MS_W-1:0]  confirm_ms;
  } cfg_t;

  // Per-pot flags kept in flip-flops
  typedef struct packed {
    logic ready;
    logic cand;
  } flags_t;

  // Per-pot entry kept in RAM
  typedef struct packed {
    logic [WEIGHT_W-1:0] ref_wt;
    logic [WEIGHT_W-1:0] peak_wt;
    logic [MS_W-1:0]     since_ms;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Confirmed event
  typedef struct packed {
    logic [WALL_W-1:0]   event_time;
    logic [WEIGHT_W-1:0] water_amount;
    logic [POT_W-1:0]    event_pot;
  } event_t;

endpackage

/* src/wed_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module wed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/wed_update.sv */
// Per-pot state update and event decision for one sample.
module wed_update import wed_pkg::*; (
  input  cfg_t                cfg,
  input  flags_t              flags_in,
  input  entry_t              entry_in,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [MS_W-1:0]     now_ms,
  output flags_t              flags_out,
  output entry_t              entry_out,
  output logic                fire,
  output logic [WEIGHT_W-1:0] water_amount
);

  logic signed [WEIGHT_W:0]   w25;
  logic signed [WEIGHT_W:0]   ref25;
  logic signed [WEIGHT_W:0]   rise;
  logic                       below_min;
  logic                       opens;
  logic                       new_peak;
  logic [WEIGHT_W-1:0]        peak_nxt;
  logic [MS_W-1:0]            since_nxt;
  logic signed [WEIGHT_W+1:0] drop_lim;
  logic                       drops;
  logic [MS_W-1:0]            elapsed;
  logic                       held;
  logic signed [WEIGHT_W:0]   gain;

  // Reference and rise
  assign w25       = $signed({weight[WEIGHT_W-1], weight});
  assign ref25     = $signed({entry_in.ref_wt[WEIGHT_W-1], entry_in.ref_wt});
  assign below_min = w25 < $signed({2'b00, cfg.min_valid});
  assign rise      = w25 - ref25;
  assign opens     = rise >= $signed({2'b00, cfg.threshold});

  // Peak tracking while a candidate is open
  assign new_peak  = w25 > $signed({entry_in.peak_wt[WEIGHT_W-1], entry_in.peak_wt});
  assign peak_nxt  = new_peak ? weight : entry_in.peak_wt;
  assign since_nxt = new_peak ? now_ms : entry_in.since_ms;
  assign drop_lim  = $signed({{2{peak_nxt[WEIGHT_W-1]}}, peak_nxt})
                   - $signed({3'b000, cfg.stable});
  assign drops     = $signed({w25[WEIGHT_W], w25}) < drop_lim;

  // Hold time, wraps mod 2^32
  assign elapsed = now_ms - since_nxt;
  assign held    = elapsed >= cfg.confirm_ms;

  // Amount added, clamped at zero
  assign gain         = $signed({peak_nxt[WEIGHT_W-1], peak_nxt}) - ref25;
  assign water_amount = gain[WEIGHT_W] ? '0 : gain[WEIGHT_W-1:0];

  // Next state
  always_comb begin
    flags_out = flags_in;
    entry_out = entry_in;
    fire      = 1'b0;
    if (!flags_in.ready) begin
      if (!below_min) begin
        flags_out.ready  = 1'b1;
        entry_out.ref_wt = weight;
      end
    end else if (!flags_in.cand) begin
      if (opens) begin
        flags_out.cand     = 1'b1;
        entry_out.peak_wt  = weight;
        entry_out.since_ms = now_ms;
      end
    end else begin
      entry_out.peak_wt  = peak_nxt;
      entry_out.since_ms = since_nxt;
      if (drops) begin
        flags_out.cand = 1'b0;
      end else if (held) begin
        fire             = 1'b1;
        entry_out.ref_wt = peak_nxt;
        flags_out.cand   = 1'b0;
      end
    end
  end

endmodule

/* src/wed_outq.sv */
// Small output queue that decouples the result stream from the update stage.
module wed_outq import wed_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  event_t           push_data,
  input  logic             pop,
  output logic             not_empty,
  output event_t           head,
  output logic [OQ_CW-1:0] count
);

  event_t           q_r [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic             do_pop;

  assign not_empty = count_r != '0;
  assign do_pop    = pop && not_empty;
  assign head      = q_r[rd_ptr_r];
  assign count     = count_r;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + OQ_CW'(push) - OQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/watering_event_detector.sv */
// Watering event detector top level: input stage, per-pot RAM, update stage, output queue.
// An accepted word is registered into the update stage, which pushes its event into the output
// queue; out_tvalid is high once the queue holds it, so the result word can leave after that.
// Throughput: one word per cycle; RAM read at accept, written back the next cycle with one
// forwarding register. in_tready drops while queued plus in-flight events reach OQ_DEPTH.
// Reset (rst_n low, synchronous) clears pot flags, config and output queue; no clear pass.
module watering_event_detector import wed_pkg::*; #(
  parameter int unsigned NUM_POTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: pot_index[2:0], weight[26:3], now_ms[58:27], wall_time[90:59], zero pad
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  // out_tdata: event_pot[2:0], water_amount[26:3], event_time[58:27], zero pad
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned AW = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;

  cfg_t                cfg_r;
  logic [POT_W-1:0]    in_pot;
  logic [WEIGHT_W-1:0] in_weight;
  logic [MS_W-1:0]     in_now;
  logic [WALL_W-1:0]   in_wall;
  logic                in_acc;
  logic                in_range;

  logic                s1_valid_r;
  logic [AW-1:0]       s1_addr_r;
  logic [POT_W-1:0]    s1_pot_r;
  logic [WEIGHT_W-1:0] s1_weight_r;
  logic [MS_W-1:0]     s1_now_r;
  logic [WALL_W-1:0]   s1_wall_r;

  logic [NUM_POTS-1:0] ready_r;
  logic [NUM_POTS-1:0] cand_r;
  entry_t              ram_rdata;
  entry_t              entry_cur;
  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  entry_t              fwd_data_r;

  flags_t              flags_cur;
  flags_t              flags_new;
  entry_t              entry_new;
  logic                fire;
  logic [WEIGHT_W-1:0] amount;
  event_t              ev;
  event_t              q_head;
  logic                q_not_empty;
  logic [OQ_CW-1:0]    q_count;
  logic [OQ_CW-1:0]    q_load;

  // Input unpacking
  assign in_pot    = in_tdata[POT_W-1:0];
  assign in_weight = in_tdata[POT_W +: WEIGHT_W];
  assign in_now    = in_tdata[POT_W+WEIGHT_W +: MS_W];
  assign in_wall   = in_tdata[POT_W+WEIGHT_W+MS_W +: WALL_W];
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = 32'(in_pot) < NUM_POTS;

  // Accept while the queue can hold every result still possible
  assign q_load    = q_count + OQ_CW'(s1_valid_r);
  assign in_tready = q_load < OQ_CW'(OQ_DEPTH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_valid  <= MIN_VALID_RST;
      cfg_r.threshold  <= THRESHOLD_RST;
      cfg_r.stable     <= STABLE_RST;
      cfg_r.confirm_ms <= CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_VALID:  cfg_r.min_valid  <= cfg_wdata[THR_W-1:0];
        CFG_THRESHOLD:  cfg_r.threshold  <= cfg_wdata[THR_W-1:0];
        CFG_STABLE:     cfg_r.stable     <= cfg_wdata[THR_W-1:0];
        CFG_CONFIRM_MS: cfg_r.confirm_ms <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc && in_range;
    end
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    s1_addr_r   <= AW'(in_pot);
    s1_pot_r    <= in_pot;
    s1_weight_r <= in_weight;
    s1_now_r    <= in_now;
    s1_wall_r   <= in_wall;
  end

  // Per-pot entry store
  wed_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_POTS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (entry_new),
    .raddr (AW'(in_pot)),
    .rdata (ram_rdata)
  );

  // Forward the write that raced the read of this word
  assign entry_cur = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= entry_new;
  end

  // Pot flags
  assign flags_cur.ready = ready_r[s1_addr_r];
  assign flags_cur.cand  = cand_r[s1_addr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
      cand_r  <= '0;
    end else if (s1_valid_r) begin
      ready_r[s1_addr_r] <= flags_new.ready;
      cand_r[s1_addr_r]  <= flags_new.cand;
    end
  end

  wed_update u_update (
    .cfg          (cfg_r),
    .flags_in     (flags_cur),
    .entry_in     (entry_cur),
    .weight       (s1_weight_r),
    .now_ms       (s1_now_r),
    .flags_out    (flags_new),
    .entry_out    (entry_new),
    .fire         (fire),
    .water_amount (amount)
  );

  // Result queue
  assign ev.event_pot    = s1_pot_r;
  assign ev.water_amount = amount;
  assign ev.event_time   = s1_wall_r;

  wed_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && fire),
    .push_data (ev),
    .pop       (out_tready),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  assign out_tvalid = q_not_empty;
  assign out_tdata  = {{(OUT_DW - $bits(event_t)){1'b0}}, q_head};

endmodule

/* src/wed_checker.sv */
// Port-level checks for the watering event detector, bound to the top level.
module wed_checker import wed_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Padding above the event fields stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DW-1:$bits(event_t)] == '0)
    else $error("nonzero padding in result word");

  // A result into an empty queue comes from a word taken earlier and held in the update stage register
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input word");

  // Reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind watering_event_detector wed_checker u_wed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/testbench.sv */
// Self-checking testbench for the watering event detector: scale samples in, watering events out.
module testbench import wed_pkg::*; ();

  localparam int POTS = 8;

  // One scale sample, packed in tdata order (pot in the low bits)
  typedef struct packed {
    logic [WALL_W-1:0]          wall_time;
    logic [MS_W-1:0]            now_ms;
    logic signed [WEIGHT_W-1:0] weight;
    logic [POT_W-1:0]           pot;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  watering_event_detector #(.NUM_POTS(POTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the detector settings
  int          min_valid_cfg = 100;
  int          threshold_cfg = 500;
  int          stable_cfg    = 50;
  logic [31:0] confirm_cfg   = 32'd10000;

  // Shadow copy of the per-pot state
  logic        pot_ready  [POTS] = '{default: 1'b0};
  int          ref_wt     [POTS] = '{default: 0};
  logic        cand_open  [POTS] = '{default: 1'b0};
  int          peak_wt    [POTS] = '{default: 0};
  logic [31:0] peak_since [POTS] = '{default: '0};

  // Stimulus side view of each pot, used to build plausible watering runs
  logic gen_ready [POTS] = '{default: 1'b0};
  int   gen_level [POTS] = '{default: 0};

  sample_t sample_backlog[$];
  event_t  pending_events[$];
  int      words_queued = 0;
  int      words_taken  = 0;
  int      events_seen  = 0;
  int      mismatches   = 0;

  task automatic flag_mismatch(string msg);
    if (mismatches < 200)
      $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int rnd(int lo, int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  function automatic int clamp_wt(int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Apply one accepted sample to the shadow state; queue the event it confirms
  function automatic void track_weight(sample_t s);
    int     p;
    int     w;
    int     amt;
    event_t ev;
    p = s.pot;
    w = $signed(s.weight);
    if (p >= POTS) return;
    // first plausible weight becomes the reference
    if (!pot_ready[p]) begin
      if (w >= min_valid_cfg) begin
        pot_ready[p] = 1'b1;
        ref_wt[p]    = w;
      end
      return;
    end
    // a large enough rise opens a candidate, never confirmed by the same sample
    if (!cand_open[p]) begin
      if (w - ref_wt[p] >= threshold_cfg) begin
        cand_open[p]  = 1'b1;
        peak_wt[p]    = w;
        peak_since[p] = s.now_ms;
      end
      return;
    end
    if (w > peak_wt[p]) begin
      peak_wt[p]    = w;
      peak_since[p] = s.now_ms;
    end
    if (w < peak_wt[p] - stable_cfg) begin
      cand_open[p] = 1'b0;
      return;
    end
    // elapsed time wraps modulo 2^32
    if (s.now_ms - peak_since[p] < confirm_cfg) return;
    amt = peak_wt[p] - ref_wt[p];
    if (amt < 0) amt = 0;
    ev.event_pot    = p[POT_W-1:0];
    ev.water_amount = amt[WEIGHT_W-1:0];
    ev.event_time   = s.wall_time;
    pending_events.push_back(ev);
    ref_wt[p]    = peak_wt[p];
    cand_open[p] = 1'b0;
  endfunction

  function automatic void queue_sample(int pot, int wt, logic [MS_W-1:0] now);
    sample_t s;
    s.pot       = pot[POT_W-1:0];
    s.weight    = wt[WEIGHT_W-1:0];
    s.now_ms    = now;
    s.wall_time = $urandom();
    sample_backlog.push_back(s);
    words_queued++;
  endfunction

  // One watering run on a pot: settle, rise, a few peaks and wobbles, then confirm or drop
  function automatic void queue_watering(int p);
    int          base;
    int          peak;
    int          w;
    int          n;
    int          wobble;
    logic [31:0] t;
    logic [31:0] since;
    t = $urandom();
    wobble = (stable_cfg < 300) ? stable_cfg : 300;
    if (!gen_ready[p]) begin
      if (min_valid_cfg > 0 && rnd(0, 1) == 1)
        queue_sample(p, clamp_wt(min_valid_cfg - 1 - rnd(0, 500)), t);
      base = clamp_wt(min_valid_cfg + rnd(0, 3000));
      queue_sample(p, base, t);
      gen_ready[p] = 1'b1;
      gen_level[p] = base;
    end
    base = gen_level[p];
    // quiet samples that stay under the threshold
    n = rnd(0, 2);
    repeat (n) begin
      t += rnd(1, 1000);
      if (threshold_cfg > 0)
        w = clamp_wt(base + rnd(0, threshold_cfg - 1));
      else
        w = clamp_wt(base - 1 - rnd(0, 200));
      queue_sample(p, w, t);
    end
    t += rnd(1, 1000);
    peak = clamp_wt(base + threshold_cfg + rnd(0, 2000));
    queue_sample(p, peak, t);
    since = t;
    n = rnd(0, 3);
    repeat (n) begin
      t += rnd(0, 200);
      if (rnd(0, 1) == 1) begin
        peak  = clamp_wt(peak + rnd(1, 300));
        w     = peak;
        since = t;
      end else begin
        w = clamp_wt(peak - rnd(0, wobble));
      end
      queue_sample(p, w, t);
    end
    if (rnd(0, 3) != 0) begin
      if (confirm_cfg != 0 && rnd(0, 1) == 1)
        queue_sample(p, peak, since + confirm_cfg - 1);
      queue_sample(p, clamp_wt(peak - rnd(0, wobble)), since + confirm_cfg + rnd(0, 3));
      gen_level[p] = peak;
    end else begin
      queue_sample(p, clamp_wt(peak - stable_cfg - 1 - rnd(0, 100)), t + rnd(0, 100));
    end
  endfunction

  function automatic void fill_random(int n_items);
    int goal;
    goal = words_queued + n_items;
    while (words_queued < goal) begin
      if (rnd(0, 6) == 0)
        queue_sample(rnd(0, POTS - 1), int'($urandom()), $urandom());
      else
        queue_watering(rnd(0, POTS - 1));
    end
  endfunction

  // Wait until every word is taken and every event has come out, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (words_taken != words_queued || pending_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MIN_VALID:  min_valid_cfg = int'(val[THR_W-1:0]);
      CFG_THRESHOLD:  threshold_cfg = int'(val[THR_W-1:0]);
      CFG_STABLE:     stable_cfg    = int'(val[THR_W-1:0]);
      CFG_CONFIRM_MS: confirm_cfg   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] mv, logic [31:0] thr, logic [31:0] st,
                             logic [31:0] cm);
    wait_idle();
    set_reg(CFG_MIN_VALID, mv);
    set_reg(CFG_THRESHOLD, thr);
    set_reg(CFG_STABLE, st);
    set_reg(CFG_CONFIRM_MS, cm);
    @(negedge clk);
  endtask

  // Sender: one word per handshake, random gap after each word
  sample_t on_bus;
  int      send_gap  = 0;
  bit      send_idle = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_weight(on_bus);
        words_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          on_bus = sample_backlog.pop_front();
          in_tdata  <= {{(IN_DW - $bits(sample_t)){1'b0}}, on_bus};
          in_tvalid <= 1'b1;
          send_gap = send_idle ? rnd(0, 4) : 0;
          if (rnd(0, 29) == 0) send_idle = !send_idle;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles, so the output queue fills and the input backs up
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && words_taken >= 400) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each event word, random stall after each
  int rcv_wait  = 0;
  bit rcv_idle  = 1'b1;

  always @(posedge clk) begin
    event_t got;
    event_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(event_t)-1:0];
        events_seen++;
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected event word, pot %0d", got.event_pot));
        end else begin
          want = pending_events.pop_front();
          if (got.event_pot !== want.event_pot)
            flag_mismatch($sformatf("event_pot got %0d want %0d",
                                    got.event_pot, want.event_pot));
          if (got.water_amount !== want.water_amount)
            flag_mismatch($sformatf("water_amount got %0d want %0d (pot %0d)",
                                    got.water_amount, want.water_amount, want.event_pot));
          if (got.event_time !== want.event_time)
            flag_mismatch($sformatf("event_time got %0h want %0h (pot %0d)",
                                    got.event_time, want.event_time, want.event_pot));
        end
        rcv_wait = rcv_idle ? rnd(0, 4) : 0;
        if (rnd(0, 19) == 0) rcv_idle = !rcv_idle;
      end else begin
        if (rcv_wait > 0) rcv_wait--;
      end
      out_tready <= (rcv_wait == 0 && hold_left == 0);
    end
  end

  // Main sequence
  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reference setup, threshold edge, hold edge, confirm
    queue_sample(0, -8388608, 32'd0);
    queue_sample(0, 99, 32'd0);
    queue_sample(0, 100, 32'd0);
    queue_sample(0, 599, 32'd1000);
    queue_sample(0, 600, 32'd1000);
    queue_sample(0, 600, 32'd10999);
    queue_sample(0, 550, 32'd11000);
    // new peak restarts the timer, fall past the stable band drops, timer wraps
    queue_sample(1, 1000, 32'd0);
    queue_sample(1, 2000, 32'hFFFF_F000);
    queue_sample(1, 2100, 32'hFFFF_F010);
    queue_sample(1, 2049, 32'hFFFF_F020);
    queue_sample(1, 2000, 32'hFFFF_FF00);
    queue_sample(1, 2000, 32'hFFFF_FF00 + 32'd10000);
    // full-scale weight
    queue_sample(2, 100, 32'd0);
    queue_sample(2, 8388607, 32'd5);
    queue_sample(2, 8388607, 32'd10005);
    // remaining pots, odd first samples
    queue_sample(3, 8388607, 32'hFFFF_FFFF);
    queue_sample(3, -1, 32'h0);
    queue_sample(4, 12345, 32'h8000_0000);
    queue_sample(5, -100, 32'h5555_5555);
    queue_sample(5, 101, 32'hAAAA_AAAA);
    queue_sample(6, 100, 32'd7);
    queue_sample(7, 4096, 32'd9);
    for (k = 0; k < POTS; k++) gen_ready[k] = 1'b0;

    // defaults after reset
    wait_idle();
    for (k = 0; k < POTS; k++) begin
      gen_ready[k] = pot_ready[k];
      gen_level[k] = ref_wt[k];
    end
    fill_random(300);

    // everything at its minimum: zero threshold, zero band, immediate confirm
    load_config(32'd0, 32'd0, 32'd0, 32'd0);
    fill_random(200);

    // everything at its maximum; upper bits of the narrow registers are dropped
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    fill_random(80);

    // assorted mid-range settings
    repeat (3) begin
      load_config(rnd(0, 3000), rnd(1, 5000), rnd(0, 500),
                  (rnd(0, 3) == 0) ? $urandom() : rnd(0, 50000));
      fill_random(290);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
